// File: design/ebh_pkg.sv
package ebh_pkg;
  localparam int MaxEdges = 31;
  localparam int EdgeW = 5;
  localparam int BinW = 5;
  localparam int NumBins = MaxEdges + 1;

  localparam logic [1:0] CmdSample = 2'd0;
  localparam logic [1:0] CmdEmit   = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;
  localparam logic [1:0] CmdEdge   = 2'd3;

  localparam logic [1:0] RegNormalize = 2'd0;
  localparam logic [1:0] RegInnerOnly = 2'd1;
  localparam logic [1:0] RegEmitOnSmp = 2'd2;
  localparam logic [1:0] RegEdgeCount = 2'd3;

  localparam logic [31:0] SampleTop = 32'h7FFF_FFFF;
endpackage

// File: design/edge_binned_histogram_top.sv
// Edge-binned histogram of Q16.16 samples. One shared 32-bit comparator
// classifies a sample by walking the edges in use, one edge a cycle, then
// the counter is bumped (saturating). An emission walks the shown bins
// twice: once to find the largest count, once to send each bin; with
// normalize set each bin goes through a 48-step restoring divider (one
// quotient bit a cycle). Each bin is read only after the receiver has taken
// the one before. The counters live in a 32-entry memory with valid bits, so
// clear only resets the valid bits. Input and configuration ready are low
// while a word is in progress.
module edge_binned_histogram_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic signed [31:0] sample_i,
  input  logic [ebh_pkg::EdgeW-1:0] edge_index_i,
  input  logic signed [31:0] edge_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [ebh_pkg::BinW-1:0] bin_number_o,
  output logic [31:0] bin_value_o,
  output logic        last_o,
  output logic        empty_res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ebh_pkg::*;

  localparam logic [2:0] SIdle = 3'd0, SClass = 3'd1, SBump = 3'd2, SMax = 3'd3,
                         SRead = 3'd4, SDiv = 3'd5, SOut = 3'd6, SWb = 3'd7;

  logic [2:0] state_q, state_d;
  logic normalize_q, inner_q, eos_q;
  logic [4:0] edge_count_q;
  logic signed [31:0] edges_q [MaxEdges];
  logic [31:0] cnt_mem [NumBins];
  logic [NumBins-1:0] cvalid_q;
  logic [31:0] rd_q;
  logic [4:0] idx_q, lo_q, hi_q;
  logic [4:0] kcnt_q;
  logic signed [31:0] smp_q;
  logic [31:0] max_q;
  logic [47:0] dividend_q;
  logic [31:0] rem_q;
  logic [5:0] dstep_q;
  logic [31:0] quo_q;
  logic [5:0] nbins;
  logic [4:0] n_use;
  logic [4:0] lo_new, hi_new;
  logic rd_pending_q, rd_pending_d;

  assign n_use = (edge_count_q > 5'(MaxEdges)) ? 5'(MaxEdges) : edge_count_q;
  assign nbins = {1'b0, n_use} + 6'd1;
  assign lo_new = inner_q ? 5'd1 : 5'd0;
  assign hi_new = inner_q ? 5'(nbins - 6'd1) : 5'(nbins);

  assign in_ready_o  = (state_q == SIdle) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == SIdle);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  logic [31:0] rdv;
  assign rdv = cvalid_q[idx_q] ? rd_q : 32'd0;

  logic [32:0] rem_sh;
  assign rem_sh = {rem_q, dividend_q[47]};

  // hi == 32 wraps to 0 in 5 bits only when inner_only is clear and n=31
  logic hi_full;
  assign hi_full = !inner_q && (nbins == 6'd32);
  logic [5:0] hi6, lo6;
  assign hi6 = hi_full ? 6'd32 : {1'b0, hi_q};
  assign lo6 = {1'b0, lo_q};
  logic empty_list;
  assign empty_list = (hi6 <= lo6);

  always_ff @(posedge clk_i) begin
    rd_q <= cnt_mem[idx_q];
    if (state_q == SBump) begin
      cnt_mem[idx_q] <= cvalid_q[idx_q] ? ((rd_q == '1) ? rd_q : rd_q + 32'd1) : 32'd1;
    end
  end

  // memory read data is valid while rd_pending is set; rd_pending alternates during a read
  always_comb begin
    case (state_q)
      SClass: rd_pending_d = (kcnt_q >= n_use) && !rd_pending_q;
      SMax, SRead: rd_pending_d = !rd_pending_q;
      default: rd_pending_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      normalize_q <= 1'b1; inner_q <= 1'b1; eos_q <= 1'b1;
      edge_count_q <= 5'd1;
      edges_q <= '{default: '0};
      cvalid_q <= '0;
      idx_q <= '0; lo_q <= '0; hi_q <= '0; kcnt_q <= '0;
      out_valid_o <= 1'b0; rd_pending_q <= 1'b0;
      max_q <= '0; dstep_q <= '0;
      smp_q <= '0; dividend_q <= '0; rem_q <= '0; quo_q <= '0;
      bin_number_o <= '0; bin_value_o <= '0; last_o <= 1'b0; empty_res_o <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_pending_q <= rd_pending_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegNormalize: normalize_q <= cfg_data_i[0];
          RegInnerOnly: inner_q <= cfg_data_i[0];
          RegEmitOnSmp: eos_q <= cfg_data_i[0];
          RegEdgeCount: begin
            edge_count_q <= cfg_data_i[4:0];
            cvalid_q <= '0;
          end
          default: ;
        endcase
      end
      if (out_acc) out_valid_o <= 1'b0;
      case (state_q)
        SIdle: if (in_acc) begin
          smp_q <= sample_i;
          kcnt_q <= '0;
          idx_q <= (command_i == CmdEmit) ? lo_new : 5'd0;
          lo_q <= lo_new;
          hi_q <= hi_new;
          max_q <= '0;
          case (command_i)
            CmdSample: ;
            CmdEmit: ;
            CmdClear: cvalid_q <= '0;
            CmdEdge: if (edge_index_i < 5'(MaxEdges)) begin
              edges_q[edge_index_i] <= edge_value_i;
              cvalid_q <= '0;
            end
            default: ;
          endcase
        end
        SClass: begin
          if (kcnt_q < n_use) begin
            if (edges_q[kcnt_q] <= smp_q) idx_q <= idx_q + 5'd1;
            kcnt_q <= kcnt_q + 5'd1;
          end
        end
        SBump: begin
          cvalid_q[idx_q] <= 1'b1;
          lo_q <= lo_new;
          hi_q <= hi_new;
          max_q <= '0;
          idx_q <= lo_new;
        end
        SMax: begin
          if (rd_pending_q) begin
            if (rdv > max_q) max_q <= rdv;
            if (idx_q + 5'd1 == hi_q || {1'b0, idx_q} + 6'd1 == 6'd32) idx_q <= lo_q;
            else idx_q <= idx_q + 5'd1;
          end
        end
        SRead: begin
          if (rd_pending_q) begin
            dividend_q <= {rdv, 16'd0};
            quo_q <= rdv; rem_q <= '0; dstep_q <= '0;
          end
        end
        SDiv: begin
          dividend_q <= {dividend_q[46:0], 1'b0};
          if (rem_sh >= {1'b0, max_q}) begin
            rem_q <= 32'(rem_sh - {1'b0, max_q});
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh[31:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          dstep_q <= dstep_q + 6'd1;
        end
        SOut: if (!out_valid_o) begin
          out_valid_o <= 1'b1;
          bin_number_o <= empty_list ? 5'd0 : idx_q;
          bin_value_o <= (empty_list || (normalize_q && max_q == '0)) ? 32'd0 : quo_q;
          last_o <= empty_list || ({1'b0, idx_q} + 6'd1 == hi6);
          empty_res_o <= empty_list;
        end
        SWb: if (out_acc) idx_q <= idx_q + 5'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (in_acc) begin
        case (command_i)
          CmdSample: state_d = (sample_i == SampleTop) ? SIdle : SClass;
          CmdEmit:   state_d = SMax;
          default:   state_d = SIdle;
        endcase
      end
      SClass: if (kcnt_q >= n_use) state_d = rd_pending_q ? SBump : SClass;
      SBump: state_d = eos_q ? SMax : SIdle;
      SMax: if (empty_list) state_d = SOut;
        else if (rd_pending_q && {1'b0, idx_q} + 6'd1 == hi6) state_d = SRead;
      SRead: if (rd_pending_q) state_d = normalize_q ? SDiv : SOut;
      SDiv: if (dstep_q == 6'd47) state_d = SOut;
      SOut: if (!out_valid_o) state_d = SWb;
      SWb: if (out_acc) begin
        if (last_o) state_d = SIdle;
        else state_d = SRead;
      end
      default: state_d = SIdle;
    endcase
  end

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_value_o))
    else $error("result word changed while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken during emission");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_o)
    else $error("empty list word without last");
endmodule

// File: test/edge_binned_histogram_top_tb.sv
`timescale 1ns / 100ps

module edge_binned_histogram_top_tb;
  import ebh_pkg::*;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] smp;
    logic [4:0]  eidx;
    logic [31:0] eval;
  } word_t;

  typedef struct packed {
    logic [4:0]  bin;
    logic [31:0] val;
    logic        last;
    logic        empty;
  } bin_word_t;

  typedef struct {
    word_t     w;
    bit        fixed;
    bin_word_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic signed [31:0] sample_i = '0;
  logic [4:0]  edge_index_i = '0;
  logic signed [31:0] edge_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [4:0]  bin_number_o;
  logic [31:0] bin_value_o;
  logic        last_o;
  logic        empty_res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  edge_binned_histogram_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] edge_tab [MaxEdges];
  logic [31:0] bin_tab [NumBins];
  bit          norm_q, inner_q, emit_smp_q;
  logic [4:0]  n_edges_q;

  bin_word_t   bins_due [$];
  int          errors = 0;
  int          cycles = 0;
  int          snd_idle = 0, rcv_stall = 0;
  bit          hold_off = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %0h want %0h", what, got, exp);
    errors++;
  endtask

  function automatic int in_use();
    return (n_edges_q > MaxEdges) ? MaxEdges : n_edges_q;
  endfunction

  function automatic void clear_bins();
    foreach (bin_tab[i]) bin_tab[i] = '0;
  endfunction

  function automatic void push_histogram();
    int nb, lo, hi;
    logic [31:0] mx;
    logic [63:0] v;
    bin_word_t b;
    nb = in_use() + 1;
    lo = inner_q ? 1 : 0;
    hi = inner_q ? nb - 1 : nb;
    mx = '0;
    if (hi <= lo) begin
      b = '{bin: 5'd0, val: 32'd0, last: 1'b1, empty: 1'b1};
      bins_due.push_back(b);
      return;
    end
    for (int i = lo; i < hi; i++) if (bin_tab[i] > mx) mx = bin_tab[i];
    for (int i = lo; i < hi; i++) begin
      v = {32'd0, bin_tab[i]};
      if (norm_q) v = (mx != 0) ? (v << 16) / {32'd0, mx} : 64'd0;
      b = '{bin: i[4:0], val: v[31:0], last: (i + 1 == hi), empty: 1'b0};
      bins_due.push_back(b);
    end
  endfunction

  function automatic void predict_word(input word_t w);
    int k;
    case (w.cmd)
      CmdSample: begin
        if (w.smp == SampleTop) return;
        k = 0;
        for (int i = 0; i < in_use(); i++)
          if ($signed(edge_tab[i]) <= $signed(w.smp)) k++;
        if (bin_tab[k] != 32'hFFFF_FFFF) bin_tab[k]++;
        if (emit_smp_q) push_histogram();
      end
      CmdEmit: push_histogram();
      CmdClear: clear_bins();
      default: if (w.eidx < MaxEdges) begin
        edge_tab[w.eidx] = w.eval;
        clear_bins();
      end
    endcase
  endfunction

  // leaves the word on the bus after it is taken; the next call or drain moves on
  task automatic send_word(input word_t w);
    @(negedge clk_i);
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    command_i <= w.cmd;
    sample_i <= w.smp;
    edge_index_i <= w.eidx;
    edge_value_i <= w.eval;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_word(w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (bins_due.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= d;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegNormalize: norm_q = d[0];
      RegInnerOnly: inner_q = d[0];
      RegEmitOnSmp: emit_smp_q = d[0];
      default: begin
        n_edges_q = d[4:0];
        clear_bins();
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic word_t mk(input logic [1:0] c, input logic [31:0] s,
                               input logic [4:0] ei, input logic [31:0] ev);
    word_t w;
    w.cmd = c; w.smp = s; w.eidx = ei; w.eval = ev;
    return w;
  endfunction

  function automatic word_t rnd_word(input int n);
    word_t w;
    int r;
    r = $urandom_range(99);
    w.smp = $urandom;
    w.eidx = 5'($urandom_range(31));
    w.eval = $urandom;
    if (r < 78) begin
      w.cmd = CmdSample;
      case ($urandom_range(9))
        0: w.smp = SampleTop;
        1: w.smp = 32'h8000_0000;
        2, 3, 4, 5: w.smp = $signed($urandom_range(n * 2 + 4)) - 2;
        default: ;
      endcase
      if ($urandom_range(3) != 0 && n > 0) w.smp = edge_tab[$urandom_range(n - 1)];
    end else if (r < 88) w.cmd = CmdEmit;
    else if (r < 93) w.cmd = CmdClear;
    else w.cmd = CmdEdge;
    return w;
  endfunction

  // receiver
  always @(negedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= rcv_stall);
  end

  always @(posedge clk_i) begin
    bin_word_t e;
    cycles++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bins_due.size() == 0) report("unexpected word", 64'(bin_number_o), 64'd0);
      else begin
        e = bins_due.pop_front();
        if (bin_number_o !== e.bin) report("bin_number", 64'(bin_number_o), 64'(e.bin));
        if (bin_value_o !== e.val) report("bin_value", 64'(bin_value_o), 64'(e.val));
        if (last_o !== e.last) report("last", 64'(last_o), 64'(e.last));
        if (empty_res_o !== e.empty) report("empty_res", 64'(empty_res_o), 64'(e.empty));
      end
    end
    if (cycles > 5_000_000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  row_t rows [$];

  initial begin
    row_t rw;
    bin_word_t res;
    int phase;
    foreach (edge_tab[i]) edge_tab[i] = '0;
    clear_bins();
    norm_q = 1; inner_q = 1; emit_smp_q = 1; n_edges_q = 1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // after reset: one edge, inner only, so the shown list is empty
    res = '{bin: 5'd0, val: 32'd0, last: 1'b1, empty: 1'b1};
    rows.push_back('{mk(CmdEmit, 0, 0, 0), 1'b1, res});
    rows.push_back('{mk(CmdSample, 32'h8000_0000, 0, 0), 1'b1, res});
    rows.push_back('{mk(CmdSample, SampleTop, 0, 0), 1'b0, res});
    rows.push_back('{mk(CmdEdge, 0, 5'd31, 32'hFFFF_FFFF), 1'b0, res});
    rows.push_back('{mk(CmdEdge, 0, 5'd0, 32'hFFFF_0000), 1'b0, res});
    rows.push_back('{mk(CmdEdge, 0, 5'd1, 32'h0000_0000), 1'b0, res});
    rows.push_back('{mk(CmdEdge, 0, 5'd2, 32'h0001_0000), 1'b0, res});
    rows.push_back('{mk(CmdEdge, 0, 5'd30, 32'h7FFF_FFFF), 1'b0, res});
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.fixed) begin
        send_word(rw.w);
        void'(bins_due.pop_back());
        bins_due.push_back(rw.res);
      end else send_word(rw.w);
    end
    drain();
    write_reg(RegEdgeCount, 32'd3);
    rows.delete();
    rows.push_back('{mk(CmdSample, 32'hFFFF_0000, 0, 0), 1'b0, res});
    rows.push_back('{mk(CmdSample, 32'hFFFE_FFFF, 0, 0), 1'b0, res});
    rows.push_back('{mk(CmdSample, 32'h0000_8000, 0, 0), 1'b0, res});
    rows.push_back('{mk(CmdSample, 32'h7FFF_FFFE, 0, 0), 1'b0, res});
    rows.push_back('{mk(CmdEmit, 0, 0, 0), 1'b0, res});
    rows.push_back('{mk(CmdClear, 0, 0, 0), 1'b0, res});
    rows.push_back('{mk(CmdEmit, 0, 0, 0), 1'b0, res});
    foreach (rows[i]) send_word(rows[i].w);
    drain();
    write_reg(RegNormalize, 32'd0);
    write_reg(RegInnerOnly, 32'd0);
    write_reg(RegEdgeCount, 32'd0);
    send_word(mk(CmdSample, 32'h1234_5678, 0, 0));
    send_word(mk(CmdSample, 32'hEDCB_A987, 0, 0));
    drain();
    write_reg(RegEdgeCount, 32'd31);
    for (int i = 0; i < MaxEdges; i++)
      send_word(mk(CmdEdge, 0, i[4:0], (i - 15) * 32'h0000_4000));
    send_word(mk(CmdSample, 32'd0, 0, 0));
    drain();

    // random phases with varied settings and idling
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 47; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 47; end
        default: begin snd_idle = 23; rcv_stall = 23; end
      endcase
      write_reg(RegNormalize, 32'(phase[0]));
      write_reg(RegInnerOnly, 32'(phase[1]));
      write_reg(RegEmitOnSmp, 32'((phase % 3) != 2));
      write_reg(RegEdgeCount, (phase == 5) ? 32'd31 : (phase == 6) ? 32'd1 :
                               32'($urandom_range(8)) | {27'd0, 5'($urandom) & 5'h18 & {5{phase[2]}}});
      for (int i = 0; i < in_use(); i++)
        send_word(mk(CmdEdge, 0, i[4:0], ($signed(i) - 2) * 32'h0000_8000));
      if (phase == 2) begin
        fork
          begin hold_off = 1'b1; repeat (400) @(negedge clk_i); hold_off = 1'b0; end
        join_none
      end
      for (int j = 0; j < 35; j++) send_word(rnd_word(in_use()));
      drain();
    end
    write_reg(RegNormalize, 32'd1);
    write_reg(RegInnerOnly, 32'd1);
    write_reg(RegEmitOnSmp, 32'd1);
    drain();

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: edge_binned_histogram_top.f
design/ebh_pkg.sv
design/edge_binned_histogram_top.sv
test/edge_binned_histogram_top_tb.sv
